@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/utcms_pkg.sv @@
// Types, constants and tables for the UTC date and time to milliseconds block.
package utcms_pkg;

  // Field and arithmetic widths
  localparam int FIELD_W = 7;
  localparam int OUT_W   = 43;
  localparam int CALC_W  = 45;
  localparam int N_MONTH = 12;
  localparam int N_LEAP  = 17;

  typedef logic [FIELD_W-1:0]      field_t;
  typedef logic signed [CALC_W-1:0] ms_t;
  typedef ms_t month_arr_t [N_MONTH];
  typedef ms_t leap_arr_t [N_LEAP];

  // Time units in milliseconds
  localparam ms_t MS_PER_DAY  = 45'sd86400000;
  localparam ms_t MS_PER_YEAR = 45'sd31536000000;
  localparam ms_t MS_PER_HOUR = 45'sd3600000;
  localparam ms_t MS_PER_MIN  = 45'sd60000;
  localparam ms_t MS_PER_SEC  = 45'sd1000;
  localparam ms_t MS_PER_CS   = 45'sd10;

  // Base year offset and marker for a month outside the calendar
  localparam ms_t    YEAR_BASE   = 45'sd4;
  localparam ms_t    SENTINEL_MS = -45'sd4398046511103;
  localparam field_t MONTH_FIRST = 7'd1;
  localparam field_t MONTH_LAST  = 7'd12;

  // Milliseconds before the first day of each month
  localparam month_arr_t MONTH_START_MS = '{
    45'sd0,           45'sd2678400000,  45'sd5097600000,  45'sd7776000000,
    45'sd10368000000, 45'sd13046400000, 45'sd15638400000, 45'sd18316800000,
    45'sd20995200000, 45'sd23587200000, 45'sd26265600000, 45'sd28857600000
  };

  // Leap day and leap second steps, in order of their limits
  localparam leap_arr_t LEAP_LIMIT = '{
    45'sd5097600000,    45'sd63158400000,   45'sd131328001000,
    45'sd157852801000,  45'sd257558402000,  45'sd268185602000,
    45'sd362793603000,  45'sd383788804000,  45'sd410313604000,
    45'sd510019205000,  45'sd636249605000,  45'sd762480005000,
    45'sd888710405000,  45'sd1014940805000, 45'sd1141171205000,
    45'sd1267401605000, 45'sd1393632005000
  };

  localparam leap_arr_t LEAP_ADD = '{
    45'sd86400000, 45'sd1000,     45'sd86400000, 45'sd1000,
    45'sd86400000, 45'sd1000,     45'sd1000,     45'sd86400000,
    45'sd1000,     45'sd86400000, 45'sd86400000, 45'sd86400000,
    45'sd86400000, 45'sd86400000, 45'sd86400000, 45'sd86400000,
    45'sd86400000
  };

  // Running total of the additions up to and including each step
  function automatic leap_arr_t leap_cum_f();
    leap_arr_t c;
    ms_t       run;
    run = '0;
    for (int i = 0; i < N_LEAP; i++) begin
      run  = run + LEAP_ADD[i];
      c[i] = run;
    end
    return c;
  endfunction

  localparam leap_arr_t LEAP_CUM = leap_cum_f();

  // Limits moved back by the earlier additions, so each compares with the base
  function automatic leap_arr_t leap_thresh_f();
    leap_arr_t t;
    for (int i = 0; i < N_LEAP; i++) begin
      t[i] = LEAP_LIMIT[i] - (LEAP_CUM[i] - LEAP_ADD[i]);
    end
    return t;
  endfunction

  localparam leap_arr_t LEAP_THRESH = leap_thresh_f();

endpackage

@@ hw/rtl/utcms_base.sv @@
// Year-plus-month base and time-of-day term for one date and time.
module utcms_base
  import utcms_pkg::*;
(
  input  field_t year_two_digit,
  input  field_t month_number,
  input  field_t day_of_month,
  input  field_t hour_value,
  input  field_t minute_value,
  input  field_t second_value,
  input  field_t centisecond_value,
  output ms_t    base_ms,
  output ms_t    time_ms
);

  ms_t        year_off;
  ms_t        day_off;
  logic [3:0] month_idx;
  logic       month_ok;

  // Pick the year-plus-month sum, or the marker for a bad month
  always_comb begin
    year_off  = ms_t'($signed({1'b0, year_two_digit})) - YEAR_BASE;
    month_ok  = (month_number >= MONTH_FIRST) && (month_number <= MONTH_LAST);
    month_idx = 4'(month_number - MONTH_FIRST);
    if (month_ok) begin
      base_ms = year_off * MS_PER_YEAR + MONTH_START_MS[month_idx];
    end else begin
      base_ms = SENTINEL_MS;
    end
  end

  // Sum the day, hour, minute, second and centisecond terms
  always_comb begin
    day_off = ms_t'($signed({1'b0, day_of_month})) - ms_t'(1);
    time_ms = day_off * MS_PER_DAY
            + ms_t'($signed({1'b0, hour_value})) * MS_PER_HOUR
            + ms_t'($signed({1'b0, minute_value})) * MS_PER_MIN
            + ms_t'($signed({1'b0, second_value})) * MS_PER_SEC
            + ms_t'($signed({1'b0, centisecond_value})) * MS_PER_CS;
  end

endmodule

@@ hw/rtl/utcms_leap.sv @@
// Leap day and leap second correction and the final sum.
module utcms_leap
  import utcms_pkg::*;
(
  input  ms_t                     base_ms,
  input  ms_t                     time_ms,
  output logic signed [OUT_W-1:0] sum_ms
);

  logic [N_LEAP-1:0] pass;
  ms_t               leap_total;
  ms_t               total;

  // Steps pass as a prefix: one that fails stops every later one
  always_comb begin
    pass[0] = (base_ms >= LEAP_THRESH[0]);
    for (int i = 1; i < N_LEAP; i++) begin
      pass[i] = pass[i-1] && (base_ms >= LEAP_THRESH[i]);
    end
  end

  // Take the running addition of the last step that passed
  always_comb begin
    leap_total = '0;
    for (int i = 0; i < N_LEAP; i++) begin
      if (pass[i]) begin
        leap_total = LEAP_CUM[i];
      end
    end
  end

  // Add everything and wrap to the output width
  always_comb begin
    total  = base_ms + leap_total + time_ms;
    sum_ms = total[OUT_W-1:0];
  end

endmodule

@@ hw/rtl/utc_date_time_to_its_milliseconds_top.sv @@
// Top level: UTC date and time to a signed millisecond count since 2004.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in      | input     | in_valid / in_stall | year, month, day, hour, min, s, cs
//   out     | output    | out_valid/out_stall | timestamp_ms (43 bits, signed)
//
// Three register stages: input, base and time terms, result. One item a cycle while out_stall is low.
// An item passes the input, base-and-time and result registers on its way to result valid.
// The leap correction is a set of parallel constant compares in the last stage.
// rst clears the stage valid bits; payload registers are not reset.
// A stalled result holds its stage; earlier stages keep filling bubbles first.
module utc_date_time_to_its_milliseconds_top
  import utcms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  field_t                  year_two_digit,
  input  field_t                  month_number,
  input  field_t                  day_of_month,
  input  field_t                  hour_value,
  input  field_t                  minute_value,
  input  field_t                  second_value,
  input  field_t                  centisecond_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] timestamp_ms
);

`include "assert_macros.svh"

  // Stage valid flags
  logic v1;
  logic v2;

  // Stage one payload
  field_t s1_year;
  field_t s1_month;
  field_t s1_day;
  field_t s1_hour;
  field_t s1_minute;
  field_t s1_second;
  field_t s1_cs;

  // Stage two payload
  ms_t base2;
  ms_t time2;

  ms_t                     base_c;
  ms_t                     time_c;
  logic signed [OUT_W-1:0] sum_c;
  logic                    rdy1;
  logic                    rdy2;
  logic                    rdy3;

  // A stage moves when it is empty or the next one moves
  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  utcms_base u_base (
    .year_two_digit    (s1_year),
    .month_number      (s1_month),
    .day_of_month      (s1_day),
    .hour_value        (s1_hour),
    .minute_value      (s1_minute),
    .second_value      (s1_second),
    .centisecond_value (s1_cs),
    .base_ms           (base_c),
    .time_ms           (time_c)
  );

  utcms_leap u_leap (
    .base_ms (base2),
    .time_ms (time2),
    .sum_ms  (sum_c)
  );

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  // Capture the input fields on a transfer
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_year   <= year_two_digit;
      s1_month  <= month_number;
      s1_day    <= day_of_month;
      s1_hour   <= hour_value;
      s1_minute <= minute_value;
      s1_second <= second_value;
      s1_cs     <= centisecond_value;
    end
  end

  // Hold the base and time terms
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      base2 <= base_c;
      time2 <= time_c;
    end
  end

  // Hold the result
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      timestamp_ms <= sum_c;
    end
  end

  // Input stall only when every stage is full and the output is stalled
  `ASSERT_CLK(a_stall_full, clk, rst,
    !in_stall || (v1 && v2 && out_valid && out_stall),
    "input stalled while a stage was free")

  // A blocked first stage keeps its item
  `ASSERT_NEXT(a_s1_hold, clk, rst, v1 && !rdy2,
    v1 && $stable(s1_month) && $stable(s1_day),
    "first stage lost its item while blocked")

  // A bad month yields the marker base in the next stage
  `ASSERT_NEXT(a_bad_month, clk, rst,
    rdy2 && v1 && (s1_month == 7'd0 || s1_month > MONTH_LAST),
    v2 && (base2 == SENTINEL_MS), "bad month did not give the marker base")

endmodule
